// File: hw/rtl/tlep_pkg.sv
// ----------------------------------------------------------------------------
// tlep_pkg: shared types and constants
// Sizes, codes, register map and helpers for the two-lane exclusion step engine.
// ----------------------------------------------------------------------------
package tlep_pkg;

	// lattice size and counter width
	localparam int NSITES      = 1024;
	localparam int COUNT_WIDTH = 32;
	localparam int AW          = $clog2(NSITES);
	localparam int CNT_W       = $clog2(NSITES + 1);

	// field widths
	localparam int SITE_W  = 11;
	localparam int FRAC_W  = 16;
	localparam int PROB_W  = 17;
	localparam int COUP_W  = 18;
	localparam int OBS_W   = 16;
	localparam int RATE_W  = 20;
	localparam int OUT_CNT_W  = 32;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 40;

	localparam int ONE_FIX = 65536;

	// configuration port
	localparam int NUM_REGS = 6;
	localparam int PADDR_W  = $clog2(4 * NUM_REGS);
	localparam int REG_IDX_W = PADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_INJ_A    = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_REM_A    = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_INJ_B    = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_REM_B    = REG_IDX_W'(3);
	localparam logic [REG_IDX_W-1:0] REG_COUPLING = REG_IDX_W'(4);
	localparam logic [REG_IDX_W-1:0] REG_OBS      = REG_IDX_W'(5);

	localparam logic [PROB_W-1:0] RST_INJ_A    = PROB_W'(19661);
	localparam logic [PROB_W-1:0] RST_REM_A    = PROB_W'(39322);
	localparam logic [PROB_W-1:0] RST_INJ_B    = PROB_W'(6554);
	localparam logic [PROB_W-1:0] RST_REM_B    = PROB_W'(52429);
	localparam logic [COUP_W-1:0] RST_COUPLING = COUP_W'(65536);
	localparam logic [OBS_W-1:0]  RST_OBS      = OBS_W'(100);

	// item kinds
	localparam logic [1:0] KIND_STEP  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	// event codes
	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_INJ  = 2'd1,
		EV_REM  = 2'd2,
		EV_HOP  = 2'd3
	} event_t;

	typedef struct packed {
		logic [PROB_W-1:0] inj_a;
		logic [PROB_W-1:0] rem_a;
		logic [PROB_W-1:0] inj_b;
		logic [PROB_W-1:0] rem_b;
		logic [COUP_W-1:0] coupling;
		logic [OBS_W-1:0]  obs;
	} cfg_t;

	// sequencer to lattice
	typedef struct packed {
		logic          occ_we;
		logic [AW-1:0] occ_waddr;
		logic [1:0]    occ_wdata;   // {lane B, lane A}
		logic [AW-1:0] raddr0;
		logic [AW-1:0] raddr1;
		logic          sweep_start;
	} lat_cmd_t;

	// lattice to sequencer
	typedef struct packed {
		logic                     busy;
		logic [1:0]               occ_rd0;
		logic [1:0]               occ_rd1;
		logic [2*COUNT_WIDTH-1:0] dens_rd; // {lane B, lane A}
	} lat_sts_t;

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
		return (&c) ? c : c + COUNT_WIDTH'(1);
	endfunction

	// clamp a counter to the 32-bit readout
	function automatic logic [OUT_CNT_W-1:0] readout(input logic [COUNT_WIDTH-1:0] c);
		logic [63:0] w;
		w = 64'(c);
		return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[OUT_CNT_W-1:0];
	endfunction

endpackage

// File: hw/rtl/tlep_cfg.sv
// ----------------------------------------------------------------------------
// tlep_cfg: configuration registers
// APB-style register file holding probabilities, coupling and sweep interval.
// ----------------------------------------------------------------------------
module tlep_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tlep_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output tlep_pkg::cfg_t              cfg
);
	import tlep_pkg::*;

	cfg_t                 cfg_q;
	logic [REG_IDX_W-1:0] idx;
	logic                 wr;

	assign pready = 1'b1;
	assign idx    = paddr[PADDR_W-1:2];
	assign wr     = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inj_a    <= RST_INJ_A;
			cfg_q.rem_a    <= RST_REM_A;
			cfg_q.inj_b    <= RST_INJ_B;
			cfg_q.rem_b    <= RST_REM_B;
			cfg_q.coupling <= RST_COUPLING;
			cfg_q.obs      <= RST_OBS;
		end else if (wr) begin
			case (idx)
				REG_INJ_A:    cfg_q.inj_a    <= pwdata[PROB_W-1:0];
				REG_REM_A:    cfg_q.rem_a    <= pwdata[PROB_W-1:0];
				REG_INJ_B:    cfg_q.inj_b    <= pwdata[PROB_W-1:0];
				REG_REM_B:    cfg_q.rem_b    <= pwdata[PROB_W-1:0];
				REG_COUPLING: cfg_q.coupling <= pwdata[COUP_W-1:0];
				REG_OBS:      cfg_q.obs      <= pwdata[OBS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_INJ_A:    prdata = 32'(cfg_q.inj_a);
			REG_REM_A:    prdata = 32'(cfg_q.rem_a);
			REG_INJ_B:    prdata = 32'(cfg_q.inj_b);
			REG_REM_B:    prdata = 32'(cfg_q.rem_b);
			REG_COUPLING: prdata = 32'(cfg_q.coupling);
			REG_OBS:      prdata = 32'(cfg_q.obs);
			default:      prdata = '0;
		endcase
	end

endmodule

// File: hw/rtl/tlep_cmp.sv
// ----------------------------------------------------------------------------
// tlep_cmp: acceptance comparator
// Shared registered compare used for injection, removal and hop tests.
// ----------------------------------------------------------------------------
module tlep_cmp (
	input  logic                       clk,
	input  logic                       load,
	input  logic [tlep_pkg::RATE_W-1:0] lhs,
	input  logic [tlep_pkg::RATE_W-1:0] rhs,
	output logic                       le
);
	import tlep_pkg::*;

	logic [RATE_W-1:0] lhs_q;
	logic [RATE_W-1:0] rhs_q;

	always_ff @(posedge clk) begin
		if (load) begin
			lhs_q <= lhs;
			rhs_q <= rhs;
		end
	end

	assign le = (lhs_q <= rhs_q);

endmodule

// File: hw/rtl/tlep_lattice.sv
// ----------------------------------------------------------------------------
// tlep_lattice: occupancy and density store
// Occupancy and counter memories with clear pass after reset and the
// accumulation sweep engine.
// ----------------------------------------------------------------------------
module tlep_lattice (
	input  logic               clk,
	input  logic               arst_n,
	input  tlep_pkg::lat_cmd_t cmd,
	output tlep_pkg::lat_sts_t sts
);
	import tlep_pkg::*;

	logic [1:0]               occ_mem  [NSITES];
	logic [2*COUNT_WIDTH-1:0] dens_mem [NSITES];

	logic                     clearing_q;
	logic                     sweeping_q;
	logic                     wr_v_s1;
	logic [CNT_W-1:0]         cnt_q;
	logic [AW-1:0]            wr_addr_s1;
	logic [AW-1:0]            rd_addr0;
	logic [1:0]               occ_rd0_q;
	logic [1:0]               occ_rd1_q;
	logic [2*COUNT_WIDTH-1:0] dens_rd_q;
	logic [COUNT_WIDTH-1:0]   next_a;
	logic [COUNT_WIDTH-1:0]   next_b;

	assign rd_addr0 = sweeping_q ? cnt_q[AW-1:0] : cmd.raddr0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			sweeping_q <= 1'b0;
			wr_v_s1    <= 1'b0;
			cnt_q      <= '0;
		end else begin
			wr_v_s1 <= sweeping_q && (cnt_q != CNT_W'(NSITES));
			if (clearing_q) begin
				if (cnt_q == CNT_W'(NSITES - 1)) begin
					clearing_q <= 1'b0;
					cnt_q      <= '0;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end else if (cmd.sweep_start) begin
				sweeping_q <= 1'b1;
				cnt_q      <= '0;
			end else if (sweeping_q) begin
				if (cnt_q == CNT_W'(NSITES)) begin
					sweeping_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= cnt_q[AW-1:0];
	end

	// sweep write-back: site read last cycle, counters bumped where occupied
	assign next_a = occ_rd0_q[0] ? sat_inc(dens_rd_q[COUNT_WIDTH-1:0])
	                             : dens_rd_q[COUNT_WIDTH-1:0];
	assign next_b = occ_rd0_q[1] ? sat_inc(dens_rd_q[2*COUNT_WIDTH-1:COUNT_WIDTH])
	                             : dens_rd_q[2*COUNT_WIDTH-1:COUNT_WIDTH];

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			occ_mem[cnt_q[AW-1:0]] <= '0;
		end else if (cmd.occ_we) begin
			occ_mem[cmd.occ_waddr] <= cmd.occ_wdata;
		end
		occ_rd0_q <= occ_mem[rd_addr0];
		occ_rd1_q <= occ_mem[cmd.raddr1];
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			dens_mem[cnt_q[AW-1:0]] <= '0;
		end else if (wr_v_s1) begin
			dens_mem[wr_addr_s1] <= {next_b, next_a};
		end
		dens_rd_q <= dens_mem[rd_addr0];
	end

	assign sts.busy    = clearing_q | sweeping_q | wr_v_s1;
	assign sts.occ_rd0 = occ_rd0_q;
	assign sts.occ_rd1 = occ_rd1_q;
	assign sts.dens_rd = dens_rd_q;

endmodule

// File: hw/rtl/two_lane_exclusion_process_step.sv
// ----------------------------------------------------------------------------
// two_lane_exclusion_process_step: two-lane TASEP Monte Carlo step engine
// Sequencer around the lattice store and a shared acceptance comparator.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                 Payload
// s_axis    in   s_axis_tvalid/tready      tuser: kind; tdata: lane, site,
//                                          rand_frac, occupancy_in
// m_axis    out  m_axis_tvalid/tready      tdata: event_res, occupied,
//                                          density_count, observed
// apb       in   psel/penable/pready       six registers at 4*index
//
// An accepted hop adds the ST_WB1 state (second occupancy row
// written through the single write port of the lattice memory).
// A step that triggers an accumulation sweep adds the ST_SWEEP state:
// the sweep walks the counter memory one site per cycle.
// After reset the lattice is cleared one site per cycle; during this
// clear pass no item is taken; configuration writes are always taken.
// A result waiting on m_axis does not block intake; the sequencer only
// holds in its final state until the output register is free.
// ----------------------------------------------------------------------------
module two_lane_exclusion_process_step (
	input  logic                          clk,
	input  logic                          arst_n,
	// item input
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// [0] lane, [11:1] site, [27:12] rand_frac, [28] occupancy_in, [31:29] zero
	input  logic [tlep_pkg::IN_DATA_W-1:0] s_axis_tdata,
	// [1:0] kind
	input  logic [1:0]                    s_axis_tuser,
	// result output
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [1:0] event_res, [2] occupied, [34:3] density_count, [35] observed,
	// [39:36] zero
	output logic [tlep_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tlep_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import tlep_pkg::*;

	typedef enum logic [8:0] {
		ST_CLEAR = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_RD    = 9'b000000100,
		ST_EVAL  = 9'b000001000,
		ST_DEC   = 9'b000010000,
		ST_WB1   = 9'b000100000,
		ST_POST  = 9'b001000000,
		ST_SWEEP = 9'b010000000,
		ST_RESP  = 9'b100000000
	} state_t;

	state_t state_q;

	cfg_t     cfg;
	lat_cmd_t lat_cmd;
	lat_sts_t lat_sts;

	// captured item
	logic [1:0]             kind_q;
	logic                   lane_q;
	logic [FRAC_W-1:0]      r_q;
	logic                   occ_in_q;
	logic [AW-1:0]          a0_q;
	logic                   is_inj_q;   // step at the injection site
	logic                   is_last_q;  // step at the last site
	logic                   in_range_q; // site inside the lattice
	logic                   valid_q;    // readback addresses a real site

	// working values
	logic [1:0]             row0_q;
	logic [1:0]             row1_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	event_t                 cand_q;
	event_t                 event_q;
	logic                   occ_after_q;
	logic                   observed_q;
	logic [OBS_W-1:0]       step_cnt_q;

	// output register
	logic                   m_valid_q;
	logic [OUT_DATA_W-1:0]  m_data_q;

	// input unpack
	logic [1:0]             in_kind;
	logic                   in_lane;
	logic [SITE_W-1:0]      in_site;
	logic                   in_is_inj;
	logic                   in_in_range;

	logic                   accept_in;
	logic                   own0;
	logic                   own1;
	logic                   oth0;
	logic                   oth1;
	logic [1:0]             n_oth;
	logic [RATE_W-1:0]      rate2;
	logic [RATE_W-1:0]      cmp_lhs;
	logic [RATE_W-1:0]      cmp_rhs;
	logic                   cmp_le;
	event_t                 cand;
	event_t                 ev;
	logic                   own_new;
	logic [1:0]             row0_new;
	logic [1:0]             row1_new;
	logic [OBS_W-1:0]       step_inc;
	logic                   do_sweep;
	logic                   out_free;
	logic [COUNT_WIDTH-1:0] cnt_after;

	tlep_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tlep_lattice u_lattice (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (lat_cmd),
		.sts    (lat_sts)
	);

	tlep_cmp u_cmp (
		.clk  (clk),
		.load (state_q == ST_EVAL),
		.lhs  (cmp_lhs),
		.rhs  (cmp_rhs),
		.le   (cmp_le)
	);

	assign in_kind     = s_axis_tuser;
	assign in_lane     = s_axis_tdata[0];
	assign in_site     = s_axis_tdata[SITE_W:1];
	assign in_is_inj   = (32'(in_site) == 32'(NSITES));
	assign in_in_range = (32'(in_site) < 32'(NSITES));

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept_in     = s_axis_tvalid & s_axis_tready;

	// lane view of the two rows read at the addressed site and the one above
	assign own0  = lane_q ? lat_sts.occ_rd0[1] : lat_sts.occ_rd0[0];
	assign own1  = lane_q ? lat_sts.occ_rd1[1] : lat_sts.occ_rd1[0];
	assign oth0  = lane_q ? lat_sts.occ_rd0[0] : lat_sts.occ_rd0[1];
	assign oth1  = lane_q ? lat_sts.occ_rd1[0] : lat_sts.occ_rd1[1];
	assign n_oth = {1'b0, oth0} + {1'b0, oth1};

	// twice the hop rate: n*beta + (2-n)*1.0, never negative
	always_comb begin
		case (n_oth)
			2'd0:    rate2 = RATE_W'(2 * ONE_FIX);
			2'd1:    rate2 = RATE_W'(cfg.coupling) + RATE_W'(ONE_FIX);
			default: rate2 = RATE_W'({cfg.coupling, 1'b0});
		endcase
	end

	// pick the candidate event and its acceptance operands
	always_comb begin
		cand    = EV_NONE;
		cmp_lhs = RATE_W'(r_q);
		cmp_rhs = '0;
		if (kind_q == KIND_STEP) begin
			if (is_inj_q) begin
				cand    = own0 ? EV_NONE : EV_INJ;
				cmp_rhs = RATE_W'(lane_q ? cfg.inj_b : cfg.inj_a);
			end else if (is_last_q) begin
				cand    = own0 ? EV_REM : EV_NONE;
				cmp_rhs = RATE_W'(lane_q ? cfg.rem_b : cfg.rem_a);
			end else if (in_range_q) begin
				cand    = (own0 && !own1) ? EV_HOP : EV_NONE;
				cmp_lhs = RATE_W'({r_q, 1'b0});
				cmp_rhs = rate2;
			end
		end
	end

	// decision and new occupancy rows
	assign ev = (cand_q != EV_NONE && cmp_le) ? cand_q : EV_NONE;

	always_comb begin
		case (ev)
			EV_INJ:  own_new = 1'b1;
			EV_REM:  own_new = 1'b0;
			EV_HOP:  own_new = 1'b0;
			default: own_new = (kind_q == KIND_WRITE) ? occ_in_q
			                                          : (lane_q ? row0_q[1] : row0_q[0]);
		endcase
		row0_new = lane_q ? {own_new, row0_q[0]} : {row0_q[1], own_new};
		row1_new = lane_q ? {1'b1, row1_q[0]} : {row1_q[1], 1'b1};
	end

	assign step_inc = step_cnt_q + OBS_W'(1);
	assign do_sweep = (step_inc >= cfg.obs);

	always_comb begin
		lat_cmd.raddr0      = a0_q;
		lat_cmd.raddr1      = a0_q + AW'(1);
		lat_cmd.occ_we      = 1'b0;
		lat_cmd.occ_waddr   = a0_q;
		lat_cmd.occ_wdata   = row0_new;
		lat_cmd.sweep_start = (state_q == ST_POST) && (kind_q == KIND_STEP) && do_sweep;
		case (state_q)
			ST_DEC: begin
				lat_cmd.occ_we = (ev != EV_NONE) || (kind_q == KIND_WRITE && valid_q);
			end
			ST_WB1: begin
				lat_cmd.occ_we    = 1'b1;
				lat_cmd.occ_waddr = a0_q + AW'(1);
				lat_cmd.occ_wdata = row1_new;
			end
			default: ;
		endcase
	end

	assign out_free  = !m_valid_q || m_axis_tready;
	assign cnt_after = (observed_q && occ_after_q) ? sat_inc(cnt_q) : cnt_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			step_cnt_q <= '0;
			observed_q <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			// output register: load a new result or drop the one taken
			if (state_q == ST_RESP && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (!lat_sts.busy) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept_in) begin
						observed_q <= 1'b0;
						state_q    <= ST_RD;
					end
				end
				ST_RD:   state_q <= ST_EVAL;
				ST_EVAL: state_q <= ST_DEC;
				ST_DEC:  state_q <= (ev == EV_HOP) ? ST_WB1 : ST_POST;
				ST_WB1:  state_q <= ST_POST;
				ST_POST: begin
					if (kind_q == KIND_STEP) begin
						if (do_sweep) begin
							step_cnt_q <= '0;
							observed_q <= 1'b1;
							state_q    <= ST_SWEEP;
						end else begin
							step_cnt_q <= step_inc;
							state_q    <= ST_RESP;
						end
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_SWEEP: begin
					if (!lat_sts.busy) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item and working registers
	always_ff @(posedge clk) begin
		if (accept_in) begin
			kind_q     <= in_kind;
			lane_q     <= in_lane;
			r_q        <= s_axis_tdata[SITE_W+FRAC_W:SITE_W+1];
			occ_in_q   <= s_axis_tdata[SITE_W+FRAC_W+1];
			a0_q       <= in_is_inj ? '0 : AW'(in_site);
			is_inj_q   <= in_is_inj;
			is_last_q  <= (32'(in_site) == 32'(NSITES - 1));
			in_range_q <= in_in_range;
			case (in_kind)
				KIND_STEP:  valid_q <= in_is_inj | in_in_range;
				KIND_WRITE: valid_q <= in_in_range;
				KIND_READ:  valid_q <= in_in_range;
				default:    valid_q <= 1'b0;
			endcase
		end
		if (state_q == ST_EVAL) begin
			row0_q <= lat_sts.occ_rd0;
			row1_q <= lat_sts.occ_rd1;
			cnt_q  <= lane_q ? lat_sts.dens_rd[2*COUNT_WIDTH-1:COUNT_WIDTH]
			                 : lat_sts.dens_rd[COUNT_WIDTH-1:0];
			cand_q <= cand;
		end
		if (state_q == ST_DEC) begin
			event_q     <= ev;
			occ_after_q <= valid_q & own_new;
		end
		if (state_q == ST_RESP && out_free) begin
			m_data_q <= {4'b0, observed_q,
			             valid_q ? readout(cnt_after) : OUT_CNT_W'(0),
			             occ_after_q, event_q};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

// File: hw/rtl/tlep_checker.sv
// ----------------------------------------------------------------------------
// tlep_checker: port-level checks
// Watches the top-level ports of the step engine; bound to the top level.
// ----------------------------------------------------------------------------
module tlep_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [tlep_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic                          pready
);
	import tlep_pkg::*;

	// one item at a time: intake closes right after an item is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("intake still open after an item was taken");

	// a waiting result holds still
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// an injection leaves the entry site occupied
	a_inj_occupied: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] == EV_INJ |-> m_axis_tdata[2])
		else $error("injection reported with site empty");

	// removal and hop both leave the addressed site empty
	a_leave_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[1:0] == EV_REM || m_axis_tdata[1:0] == EV_HOP)
		|-> !m_axis_tdata[2])
		else $error("removal or hop reported with site occupied");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

endmodule

bind two_lane_exclusion_process_step tlep_checker u_tlep_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.pready        (pready)
);
